// ===== rtl/core/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg: shared definitions for the thermometer scratchpad decoder
// Frame layout constants, field widths and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package tsd_pkg;

   // Scratchpad frame layout.
   localparam int FRAME_BYTES   = 9;
   localparam int POS_W         = 4;
   localparam logic [POS_W-1:0] POS_TEMP_LSB = 4'd0;
   localparam logic [POS_W-1:0] POS_TEMP_MSB = 4'd1;
   localparam logic [POS_W-1:0] POS_REMAIN   = 4'd6;
   localparam logic [POS_W-1:0] POS_LAST     = 4'(FRAME_BYTES - 1);

   // Conversion constants.
   localparam int TICKS_PER_DEG  = 16;
   localparam int QUARTER_OFFSET = TICKS_PER_DEG / 4;

   // Field widths.
   localparam int BYTE_W    = 8;
   localparam int CENTI_W   = 19;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   // CRC-8, reflected polynomial 0x8C, one byte per call.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/thermometer_scratchpad_decoder.sv =====
// ----------------------------------------------------------------------------
// thermometer_scratchpad_decoder: one-wire thermometer scratchpad decoder
// Checks the CRC-8 of a nine-byte scratchpad and converts the temperature.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one scratchpad byte per word, bytes 0 to 8 in
// order. The CRC runs over every byte; bytes 0, 1 and 6 are kept. After the
// ninth byte one word leaves on the rsp channel: the temperature in
// hundredths of a degree in tdata and the frame status in tuser (1 = CRC
// good, 0 = CRC error with a temperature of zero). The byte count and CRC
// then restart for the next frame.
// A byte is taken into an input register; when the ninth byte of a frame
// advances from it, the frame's result is loaded into the result register.
// The block accepts one byte every cycle; the single result register sits
// between the sides, so input keeps flowing while a result waits. Only when
// a result is stalled and another frame completes does req_tready drop.
// A synchronous reset empties both registers and restarts the frame count.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream: [7:0] data_byte.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsd_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // Result stream: [18:0] temperature_centi, [23:19] zero.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // Result flag: [0] frame_status.
   output logic                                rsp_tuser
);

   logic                               in_vld_ff, in_vld_in;
   logic [tsd_pkg::BYTE_W-1:0]         in_byte_ff;
   logic [7:0]                         crc_ff, crc_in;
   logic [tsd_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [tsd_pkg::BYTE_W-1:0]         lsb_ff, msb_ff, remain_ff;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic signed [tsd_pkg::CENTI_W-1:0] temp_ff, temp_in;
   logic                               status_ff, status_in;
   logic                               is_last;
   logic                               advance;
   logic [7:0]                         crc_next;
   logic signed [tsd_pkg::CENTI_W-1:0] conv_centi;

   // Stage control: the held byte advances unless its result has nowhere to go.
   assign is_last    = (pos_ff >= tsd_pkg::POS_LAST);
   assign advance    = in_vld_ff && (!is_last || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = req_tvalid ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

   // Running CRC and frame position.
   assign crc_next = tsd_pkg::crc8_update(crc_ff, in_byte_ff);

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      if (advance) begin
         if (is_last) begin
            crc_in = 8'h00;
            pos_in = '0;
         end else begin
            crc_in = crc_next;
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Temperature conversion from the kept bytes.
   tsd_convert u_convert (
      .temp_lsb     (lsb_ff),
      .temp_msb     (msb_ff),
      .remain_count (remain_ff),
      .temp_centi   (conv_centi)
   );

   // Result register load and drain.
   assign status_in  = (crc_next == 8'h00);
   assign temp_in    = status_in ? conv_centi : '0;
   assign rsp_vld_in = (advance && is_last) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         crc_ff     <= 8'h00;
         pos_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         crc_ff     <= crc_in;
         pos_ff     <= pos_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[tsd_pkg::BYTE_W-1:0];
      end
      if (advance) begin
         unique case (pos_ff)
            tsd_pkg::POS_TEMP_LSB: lsb_ff    <= in_byte_ff;
            tsd_pkg::POS_TEMP_MSB: msb_ff    <= in_byte_ff;
            tsd_pkg::POS_REMAIN:   remain_ff <= in_byte_ff;
            default: ;
         endcase
      end
      if (advance && is_last) begin
         temp_ff   <= temp_in;
         status_ff <= status_in;
      end
   end

   // Result port.
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(tsd_pkg::RSP_TDATA_W - tsd_pkg::CENTI_W){1'b0}}, temp_ff};
   assign rsp_tuser  = status_ff;

endmodule

// ===== rtl/core/tsd_convert.sv =====
// ----------------------------------------------------------------------------
// tsd_convert: scratchpad bytes to hundredths of a degree
// Combines the temperature bytes and count remain into a signed result.
// ----------------------------------------------------------------------------
module tsd_convert (
   input  logic [tsd_pkg::BYTE_W-1:0]          temp_lsb,
   input  logic [tsd_pkg::BYTE_W-1:0]          temp_msb,
   input  logic [tsd_pkg::BYTE_W-1:0]          remain_count,
   output logic signed [tsd_pkg::CENTI_W-1:0]  temp_centi
);

   logic [15:0]        raw_word;
   logic [15:0]        raw_shift;
   logic signed [17:0] value;
   logic signed [20:0] value_x10;
   logic signed [16:0] value_div;
   logic signed [20:0] centi_wide;

   // Raw reading with the half-degree bit dropped, scaled to 1/16 degree.
   assign raw_word  = {temp_msb, temp_lsb[7:1], 1'b0};
   assign raw_shift = {raw_word[12:0], 3'b000};

   // Add the count-remain correction: raw - 0.25 C + 1 C - remain_count.
   assign value = signed'({{2{raw_shift[15]}}, raw_shift})
                + 18'(tsd_pkg::TICKS_PER_DEG) - 18'(tsd_pkg::QUARTER_OFFSET)
                - signed'({10'b0, remain_count});

   // Multiply by ten, floor-divide by sixteen, multiply by ten again.
   assign value_x10  = (21'(value) <<< 3) + (21'(value) <<< 1);
   assign value_div  = 17'(value_x10 >>> 4);
   assign centi_wide = (21'(value_div) <<< 3) + (21'(value_div) <<< 1);
   assign temp_centi = centi_wide[tsd_pkg::CENTI_W-1:0];

endmodule

// ===== rtl/core/tsd_checker.sv =====
// ----------------------------------------------------------------------------
// tsd_checker: port-level checks for the scratchpad decoder
// Watches the decoder's ports and reports violations of its behavior.
// ----------------------------------------------------------------------------
module tsd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tsd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);

   // Reset empties the result register.
   a_reset_no_result: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   // Reset empties the input register, so a byte can be taken at once.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

   // A stalled result word holds its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // A CRC error reports a zero temperature.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("CRC error with nonzero temperature");

   // The input is held off only while a result word is stalled.
   a_input_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result word");

endmodule

bind thermometer_scratchpad_decoder tsd_checker u_tsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
